>>> hdl/lidar_point_crop_filter_defines.svh
// Assertion macros used by the crop filter top level.
`ifndef LIDAR_POINT_CROP_FILTER_DEFINES_SVH
`define LIDAR_POINT_CROP_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is high.
`define LPCF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked check that also covers the reset cycles.
`define LPCF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LPCF_ASSERT(label, prop, msg)
`define LPCF_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> hdl/lpcf_pkg.sv
// Types and constants shared by the lidar point crop filter.
package lpcf_pkg;

   // Default parameter values
   localparam int DEF_INDEX_BITS    = 18;
   localparam int DEF_FIX_FRAC_BITS = 10;

   // Fixed-point and row arithmetic widths
   localparam int FIX_W     = 24;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = FIX_W + COEF_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int ROW_SHIFT = 14;
   localparam int V_W       = SUM_W - ROW_SHIFT + 1;
   localparam int ROW_W     = 4 * COEF_W;

   localparam logic signed [FIX_W-1:0] FIX_MAX = 24'sh7FFFFF;
   localparam logic signed [FIX_W-1:0] FIX_MIN = 24'sh800000;

   // Float magnitude thresholds (sign bit stripped)
   localparam logic [30:0] FLT_INF_ABS   = 31'h7F800000;
   localparam logic [30:0] FLT_RANGE_ABS = 31'h447A0000;

   // Enable bit positions
   localparam int EN_RANGE = 0;
   localparam int EN_BOX   = 1;
   localparam int EN_HIGHZ = 2;
   localparam int EN_W     = 3;

   // Register map
   localparam int CSR_IDX_W = 4;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILTER_ENABLES = 4'd0,
      REG_BOX_FRONT_X    = 4'd1,
      REG_BOX_BACK_X     = 4'd2,
      REG_BOX_FRONT_Y    = 4'd3,
      REG_BOX_BACK_Y     = 4'd4,
      REG_Z_LIMIT        = 4'd5,
      REG_ROW_X_COEFFS   = 4'd6,
      REG_ROW_Y_COEFFS   = 4'd7
   } csr_reg_type;

   localparam logic [ROW_W-1:0] ROW_X_RESET = 64'd16384;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'd1073741824;

   typedef struct packed {
      logic [EN_W-1:0]         enables;
      logic signed [FIX_W-1:0] box_front_x;
      logic signed [FIX_W-1:0] box_back_x;
      logic signed [FIX_W-1:0] box_front_y;
      logic signed [FIX_W-1:0] box_back_y;
      logic signed [FIX_W-1:0] z_limit;
      logic [ROW_W-1:0]        row_x;
      logic [ROW_W-1:0]        row_y;
   } cfg_type;

   // Stage load enables handed to the row units
   typedef struct packed {
      logic load_s2;
      logic load_s3;
   } pipe_ctl_type;

   // Pass-through part of a point
   typedef struct packed {
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [7:0]  intensity;
      logic [63:0] timestamp_ns;
   } point_type;

endpackage

>>> hdl/lpcf_csr.sv
// Configuration register file of the crop filter.
module lpcf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_wdata,
   output lpcf_pkg::cfg_type              cfg
);
   import lpcf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always accepted
   assign csr_ready = 1'b1;

   // Next register contents
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FILTER_ENABLES: cfg_in.enables     = csr_wdata[EN_W-1:0];
            REG_BOX_FRONT_X:    cfg_in.box_front_x = csr_wdata[FIX_W-1:0];
            REG_BOX_BACK_X:     cfg_in.box_back_x  = csr_wdata[FIX_W-1:0];
            REG_BOX_FRONT_Y:    cfg_in.box_front_y = csr_wdata[FIX_W-1:0];
            REG_BOX_BACK_Y:     cfg_in.box_back_y  = csr_wdata[FIX_W-1:0];
            REG_Z_LIMIT:        cfg_in.z_limit     = csr_wdata[FIX_W-1:0];
            REG_ROW_X_COEFFS:   cfg_in.row_x       = csr_wdata[ROW_W-1:0];
            REG_ROW_Y_COEFFS:   cfg_in.row_y       = csr_wdata[ROW_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enables     <= '0;
         cfg_ff.box_front_x <= '0;
         cfg_ff.box_back_x  <= '0;
         cfg_ff.box_front_y <= '0;
         cfg_ff.box_back_y  <= '0;
         cfg_ff.z_limit     <= FIX_MAX;
         cfg_ff.row_x       <= ROW_X_RESET;
         cfg_ff.row_y       <= ROW_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/lpcf_conv.sv
// Float to saturated fixed-point conversion plus NaN and range flags.
module lpcf_conv #(
   parameter int FRAC_BITS = lpcf_pkg::DEF_FIX_FRAC_BITS
) (
   input  logic [31:0]                    flt_bits,
   output logic signed [lpcf_pkg::FIX_W-1:0] fix,
   output logic                           is_nan,
   output logic                           over_range
);
   import lpcf_pkg::*;

   // Exponent at which the mantissa LSB lands on the fixed-point LSB
   localparam int Bias  = 150 - FRAC_BITS;
   localparam int MantW = 24;

   logic [7:0]        exp_v;
   logic [MantW-1:0]  mant;
   logic signed [9:0] sh;
   logic [9:0]        rsh;
   logic [MantW-1:0]  mag;
   logic              sat;

   assign is_nan     = flt_bits[30:0] > FLT_INF_ABS;
   assign over_range = flt_bits[30:0] > FLT_RANGE_ABS;

   // Right shift of the mantissa, truncating toward zero
   always_comb begin
      exp_v = flt_bits[30:23];
      mant  = (exp_v == 8'd0) ? {1'b0, flt_bits[22:0]} : {1'b1, flt_bits[22:0]};
      sh    = $signed({2'b00, ((exp_v == 8'd0) ? 8'd1 : exp_v)}) - $signed(10'(Bias));
      rsh   = 10'(-sh);
      // Any left shift of a nonzero mantissa overflows 24 bits
      sat   = (exp_v == 8'hFF) || ((mant != '0) && !sh[9]);
      if ((mant == '0) || (rsh >= 10'(MantW))) begin
         mag = '0;
      end else begin
         mag = mant >> rsh[4:0];
      end
      if (sat) begin
         fix = flt_bits[31] ? FIX_MIN : FIX_MAX;
      end else if (flt_bits[31]) begin
         fix = $signed(FIX_W'(-mag));
      end else begin
         fix = $signed(FIX_W'(mag));
      end
   end

endmodule

>>> hdl/lpcf_row.sv
// One affine row: products in one stage, sum, floor and offset in the next.
module lpcf_row (
   input  logic                              clock,
   input  lpcf_pkg::pipe_ctl_type            ctl,
   input  logic [lpcf_pkg::ROW_W-1:0]        row,
   input  logic signed [lpcf_pkg::FIX_W-1:0] fx,
   input  logic signed [lpcf_pkg::FIX_W-1:0] fy,
   input  logic signed [lpcf_pkg::FIX_W-1:0] fz,
   output logic signed [lpcf_pkg::V_W-1:0]   v
);
   import lpcf_pkg::*;

   logic signed [COEF_W-1:0] wx, wy, wz, tr;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [V_W-1:0]    v_ff, v_in;

   assign wx = $signed(row[COEF_W-1:0]);
   assign wy = $signed(row[2*COEF_W-1:COEF_W]);
   assign wz = $signed(row[3*COEF_W-1:2*COEF_W]);
   assign tr = $signed(row[4*COEF_W-1:3*COEF_W]);

   // Stage 2: weighted coordinates (16 x 24 signed, sign-extended to product width)
   assign px_in = PROD_W'(wx) * PROD_W'(fx);
   assign py_in = PROD_W'(wy) * PROD_W'(fy);
   assign pz_in = PROD_W'(wz) * PROD_W'(fz);

   // Stage 3: floor of sum / 2^14, plus translation
   always_comb begin
      sum  = SUM_W'(px_ff) + SUM_W'(py_ff) + SUM_W'(pz_ff);
      v_in = V_W'($signed(sum[SUM_W-1:ROW_SHIFT])) + V_W'(tr);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
      if (ctl.load_s3) begin
         v_ff <= v_in;
      end
   end

   assign v = v_ff;

endmodule

>>> hdl/lidar_point_crop_filter.sv
// Lidar point crop filter: range, exclusion-box and high-z point filters.
// An accepted item passes through stages 1, 2 and 3 and the output register before it is presented on rsp_.
// Throughput: one point per cycle while rsp_stall is low; each pipeline stage loads while it or its successor frees.
// Dropped points leave the pipeline at the last stage and never reach rsp_.
// Reset (synchronous) clears all stage valids and restores register defaults.
`include "lidar_point_crop_filter_defines.svh"

module lidar_point_crop_filter #(
   parameter int INDEX_BITS    = lpcf_pkg::DEF_INDEX_BITS,
   parameter int FIX_FRAC_BITS = lpcf_pkg::DEF_FIX_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_wdata,
   // point input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_x_bits,
   input  logic [31:0]                    req_y_bits,
   input  logic [31:0]                    req_z_bits,
   input  logic [7:0]                     req_intensity,
   input  logic [63:0]                    req_timestamp_ns,
   input  logic [INDEX_BITS-1:0]          req_point_index,
   // kept points
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_kept_x_bits,
   output logic [31:0]                    rsp_kept_y_bits,
   output logic [31:0]                    rsp_kept_z_bits,
   output logic [7:0]                     rsp_kept_intensity,
   output logic [63:0]                    rsp_kept_timestamp_ns,
   output logic [INDEX_BITS-1:0]          rsp_kept_index
);
   import lpcf_pkg::*;

   cfg_type      cfg;
   pipe_ctl_type ctl;

   // Stage advance chain
   logic out_free, s3_adv, s2_adv, s1_adv;

   // Stage 1: converted coordinates and flags
   logic                    s1_vld_ff;
   point_type               s1_pt_ff, s1_pt_in;
   logic [INDEX_BITS-1:0]   s1_idx_ff;
   logic signed [FIX_W-1:0] s1_fx_ff, s1_fy_ff, s1_fz_ff;
   logic signed [FIX_W-1:0] cv_fx, cv_fy, cv_fz;
   logic                    nan_x, nan_y, nan_z, ovr_x, ovr_y, ovr_z;
   logic                    s1_nan_ff, s1_nanz_ff, s1_rng_ff;
   logic                    s1_nan_in, s1_rng_in;

   // Stage 2: products (in row units) and high-z flag
   logic                  s2_vld_ff;
   point_type             s2_pt_ff;
   logic [INDEX_BITS-1:0] s2_idx_ff;
   logic                  s2_nan_ff, s2_rng_ff, s2_hz_ff, s2_hz_in;

   // Stage 3: vehicle-frame coordinates
   logic                  s3_vld_ff;
   point_type             s3_pt_ff;
   logic [INDEX_BITS-1:0] s3_idx_ff;
   logic                  s3_nan_ff, s3_rng_ff, s3_hz_ff;
   logic signed [V_W-1:0] vx, vy;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   point_type             rsp_pt_ff;
   logic [INDEX_BITS-1:0] rsp_idx_ff;
   logic                  in_box, keep;

   lpcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshake: a stage loads when empty or when its successor loads
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_adv    = !s3_vld_ff || out_free;
   assign s2_adv    = !s2_vld_ff || s3_adv;
   assign s1_adv    = !s1_vld_ff || s2_adv;
   assign req_stall = !s1_adv;

   assign ctl.load_s2 = s2_adv;
   assign ctl.load_s3 = s3_adv;

   // Stage 1 conversion of the incoming beat
   lpcf_conv #(.FRAC_BITS(FIX_FRAC_BITS)) u_conv_x (
      .flt_bits (req_x_bits), .fix (cv_fx), .is_nan (nan_x), .over_range (ovr_x));
   lpcf_conv #(.FRAC_BITS(FIX_FRAC_BITS)) u_conv_y (
      .flt_bits (req_y_bits), .fix (cv_fy), .is_nan (nan_y), .over_range (ovr_y));
   lpcf_conv #(.FRAC_BITS(FIX_FRAC_BITS)) u_conv_z (
      .flt_bits (req_z_bits), .fix (cv_fz), .is_nan (nan_z), .over_range (ovr_z));

   always_comb begin
      s1_pt_in.x_bits       = req_x_bits;
      s1_pt_in.y_bits       = req_y_bits;
      s1_pt_in.z_bits       = req_z_bits;
      s1_pt_in.intensity    = req_intensity;
      s1_pt_in.timestamp_ns = req_timestamp_ns;
      s1_nan_in             = nan_x || nan_y || nan_z;
      s1_rng_in             = s1_nan_in || ovr_x || ovr_y || ovr_z;
   end

   // Stage 2 high-z compare; NaN z never counts as high
   assign s2_hz_in = !s1_nanz_ff && (s1_fz_ff > $signed(cfg.z_limit));

   // Vehicle-frame rows
   lpcf_row u_row_x (
      .clock (clock), .ctl (ctl), .row (cfg.row_x),
      .fx (s1_fx_ff), .fy (s1_fy_ff), .fz (s1_fz_ff), .v (vx));
   lpcf_row u_row_y (
      .clock (clock), .ctl (ctl), .row (cfg.row_y),
      .fx (s1_fx_ff), .fy (s1_fy_ff), .fz (s1_fz_ff), .v (vy));

   // Final keep decision
   always_comb begin
      in_box = (vx < V_W'($signed(cfg.box_front_x))) &&
               (vx > V_W'($signed(cfg.box_back_x))) &&
               (vy < V_W'($signed(cfg.box_front_y))) &&
               (vy > V_W'($signed(cfg.box_back_y)));
      keep = !((cfg.enables[EN_RANGE] && s3_rng_ff) ||
               (cfg.enables[EN_BOX] && !s3_nan_ff && in_box) ||
               (cfg.enables[EN_HIGHZ] && s3_hz_ff));
      rsp_valid_in = s3_vld_ff && keep;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_adv) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_adv) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_pt_ff   <= s1_pt_in;
         s1_idx_ff  <= req_point_index;
         s1_fx_ff   <= cv_fx;
         s1_fy_ff   <= cv_fy;
         s1_fz_ff   <= cv_fz;
         s1_nan_ff  <= s1_nan_in;
         s1_nanz_ff <= nan_z;
         s1_rng_ff  <= s1_rng_in;
      end
      if (s2_adv) begin
         s2_pt_ff  <= s1_pt_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_nan_ff <= s1_nan_ff;
         s2_rng_ff <= s1_rng_ff;
         s2_hz_ff  <= s2_hz_in;
      end
      if (s3_adv) begin
         s3_pt_ff  <= s2_pt_ff;
         s3_idx_ff <= s2_idx_ff;
         s3_nan_ff <= s2_nan_ff;
         s3_rng_ff <= s2_rng_ff;
         s3_hz_ff  <= s2_hz_ff;
      end
      if (out_free) begin
         rsp_pt_ff  <= s3_pt_ff;
         rsp_idx_ff <= s3_idx_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kept_x_bits       = rsp_pt_ff.x_bits;
   assign rsp_kept_y_bits       = rsp_pt_ff.y_bits;
   assign rsp_kept_z_bits       = rsp_pt_ff.z_bits;
   assign rsp_kept_intensity    = rsp_pt_ff.intensity;
   assign rsp_kept_timestamp_ns = rsp_pt_ff.timestamp_ns;
   assign rsp_kept_index        = rsp_idx_ff;

   // Checks
   `LPCF_ASSERT_RST(a_reset_clears_out, reset |=> !rsp_valid_ff, "output valid after reset")
   `LPCF_ASSERT(a_drop_not_presented, (s3_vld_ff && out_free && !keep) |=> !rsp_valid_ff, "dropped point reached output")
   `LPCF_ASSERT(a_highz_dropped, (s3_vld_ff && out_free && cfg.enables[EN_HIGHZ] && s3_hz_ff) |=> !rsp_valid_ff, "high point kept")
   `LPCF_ASSERT(a_s1_held, (s1_vld_ff && !s2_adv) |=> (s1_vld_ff && $stable(s1_idx_ff)), "stage 1 beat lost while blocked")
   `LPCF_ASSERT(a_s2_held, (s2_vld_ff && !s3_adv) |=> (s2_vld_ff && $stable(s2_idx_ff)), "stage 2 beat lost while blocked")

endmodule
